/* hw/rtl/elf4_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elf4_pkg
// shared types and constants for the 256-symbol lc4 byte cipher
// ----------------------------------------------------------------------------
package elf4_pkg;

    // grid side used when the top level is not told otherwise
    localparam int GRID_SIDE_DEF = 16;
    // key store and grid are both kept as a full 16 x 16 byte array
    localparam int STORE_DEPTH   = 256;
    localparam int BYTE_W        = 8;
    localparam int POS_W         = 4;

    // command codes
    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_RESTART = 2'd1,
        OP_ENCRYPT = 2'd2,
        OP_DECRYPT = 2'd3
    } t_op;

    // command beat
    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] key_index;
        logic [BYTE_W-1:0] data_byte;
    } t_in;

    // result beat
    typedef struct packed {
        logic [BYTE_W-1:0] result_byte;
        logic              symbol_missing;
    } t_out;

endpackage
`default_nettype wire

/* hw/rtl/elf4_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elf4_ram
// simple dual-port ram, one write and one registered read port (read-first)
// ----------------------------------------------------------------------------
module elf4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read, old data on a same-address clash
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hw/rtl/elsiefour_byte_cipher_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// elsiefour_byte_cipher_core
// lc4 byte cipher on a square byte grid held in block ram
// ----------------------------------------------------------------------------
// usage
//   command channel: a beat is taken on a rising edge with i_start high and
//   o_busy low. op load writes one key byte in that same cycle and never
//   raises o_busy. op restart copies the key into the grid while busy and
//   puts the marker at row 0, column 0. op encrypt / decrypt gives one
//   result beat: o_valid is high for exactly one cycle with o_out, at the
//   end of the step. the cost is set by the single grid read port: a
//   linear search of the grid (one cell a cycle), then the marker and
//   target reads, then a row and a column rotation done read-then-write
//   one cell a cycle.
//   the result beat cannot be held off by the receiver; it is shown once.
//   reset clears the controller and the marker. key store and grid contents
//   are unknown until loaded and restarted; encrypting before the first
//   restart gives unspecified bytes.
// ----------------------------------------------------------------------------
module elsiefour_byte_cipher_core #(
    parameter int GRID_SIDE = elf4_pkg::GRID_SIDE_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    output logic                o_busy,
    input  wire elf4_pkg::t_in  i_in,
    output logic                o_valid,
    output elf4_pkg::t_out      o_out
);

    localparam int AW = $clog2(elf4_pkg::STORE_DEPTH);
    localparam int PW = elf4_pkg::POS_W;
    localparam int BW = elf4_pkg::BYTE_W;
    localparam logic [PW-1:0] LAST_POS = PW'(GRID_SIDE - 1);
    localparam logic [PW:0]   SIDE_K   = (PW+1)'(GRID_SIDE);

    typedef enum logic [3:0] {
        S_IDLE, S_COPY, S_COPYW, S_SCAN, S_MARK, S_MVAL, S_RES, S_RESW,
        S_ROW, S_COL
    } t_state;

    t_state          r_state;
    elf4_pkg::t_in   r_in;
    logic [PW-1:0]   r_sr, r_sc;
    logic            r_cmp_v;
    logic [PW-1:0]   r_cmp_r, r_cmp_c;
    logic            r_found;
    logic [PW-1:0]   r_fr, r_fc, r_cr, r_cc, r_pr, r_pc;
    logic [PW:0]     r_k;
    logic [BW-1:0]   r_res;
    logic [PW-1:0]   r_mrow, r_mcol;
    logic            r_cp_v;
    logic [AW-1:0]   r_cp_addr;
    logic            r_valid;
    elf4_pkg::t_out  r_out;

    logic            k_we;
    logic [AW-1:0]   k_raddr;
    logic [BW-1:0]   k_rdata;
    logic            g_we;
    logic [AW-1:0]   g_waddr, g_raddr;
    logic [BW-1:0]   g_wdata, g_rdata;

    // reduction modulo the grid side for values below 32
    logic [PW-1:0]   mod_tab [32];
    for (genvar g = 0; g < 32; g++) begin : g_mod
        assign mod_tab[g] = PW'(g % GRID_SIDE);
    end

    logic            cmd_take;
    logic            is_enc;
    logic [PW-1:0]   dr, dc, e_cr, e_cc, d_pr, d_pc;
    logic [PW+1:0]   d_pr_sum, d_pc_sum;
    logic [PW-1:0]   cc_next, mcol1, mrow1, mrow2, mcol2, kpos;
    logic [BW-1:0]   cbyte;

    assign cmd_take = i_start && (r_state == S_IDLE);
    assign is_enc   = (r_in.op == elf4_pkg::OP_ENCRYPT);
    assign kpos     = (r_k == SIDE_K) ? '0 : r_k[PW-1:0];

    // key store: written straight from a load beat
    assign k_we    = cmd_take && (i_in.op == elf4_pkg::OP_LOAD);
    assign k_raddr = {r_sr, r_sc};

    elf4_ram #(.WIDTH(BW), .DEPTH(elf4_pkg::STORE_DEPTH)) u_key (
        .i_clk  (i_clk),
        .i_we   (k_we),
        .i_waddr(i_in.key_index),
        .i_wdata(i_in.data_byte),
        .i_raddr(k_raddr),
        .o_rdata(k_rdata)
    );

    // grid port steering
    always_comb begin
        g_we    = 1'b0;
        g_waddr = r_cp_addr;
        g_wdata = k_rdata;
        g_raddr = {r_sr, r_sc};
        case (r_state)
            S_COPY, S_COPYW: begin
                g_we = r_cp_v;
            end
            S_MARK: begin
                g_raddr = {r_mrow, r_mcol};
            end
            S_RES: begin
                g_raddr = is_enc ? {r_cr, r_cc} : {r_pr, r_pc};
            end
            S_ROW: begin
                g_raddr = {r_pr, r_k[PW-1:0]};
                g_we    = (r_k != '0);
                g_waddr = {r_pr, kpos};
                g_wdata = g_rdata;
            end
            S_COL: begin
                g_raddr = {r_k[PW-1:0], r_cc};
                g_we    = (r_k != '0);
                g_waddr = {kpos, r_cc};
                g_wdata = g_rdata;
            end
            default: begin
                g_we = 1'b0;
            end
        endcase
    end

    elf4_ram #(.WIDTH(BW), .DEPTH(elf4_pkg::STORE_DEPTH)) u_grid (
        .i_clk  (i_clk),
        .i_we   (g_we),
        .i_waddr(g_waddr),
        .i_wdata(g_wdata),
        .i_raddr(g_raddr),
        .o_rdata(g_rdata)
    );

    // position arithmetic from the marker byte
    always_comb begin
        dr       = mod_tab[{1'b0, g_rdata[7:4]}];
        dc       = mod_tab[{1'b0, g_rdata[3:0]}];
        e_cr     = mod_tab[{1'b0, r_fr} + {1'b0, dr}];
        e_cc     = mod_tab[{1'b0, r_fc} + {1'b0, dc}];
        d_pr_sum = {2'b0, r_fr} + (PW+2)'(GRID_SIDE) - {2'b0, dr};
        d_pc_sum = {2'b0, r_fc} + (PW+2)'(GRID_SIDE) - {2'b0, dc};
        d_pr     = mod_tab[d_pr_sum[PW:0]];
        d_pc     = mod_tab[d_pc_sum[PW:0]];
    end

    // marker follow and advance at the end of a step
    always_comb begin
        cc_next = mod_tab[{1'b0, r_cc} + 5'd1];
        cbyte   = is_enc ? r_res : r_in.data_byte;
        mcol1   = (r_mrow == r_pr) ? mod_tab[{1'b0, r_mcol} + 5'd1] : r_mcol;
        mrow1   = (mcol1 == r_cc) ? mod_tab[{1'b0, r_mrow} + 5'd1] : r_mrow;
        mrow2   = mod_tab[{1'b0, mrow1} + {1'b0, cbyte[7:4]}];
        mcol2   = mod_tab[{1'b0, mcol1} + {1'b0, cbyte[3:0]}];
    end

    // controller
    always_ff @(posedge i_clk) begin
        r_valid <= 1'b0;
        r_cp_v  <= 1'b0;
        r_cp_addr <= {r_sr, r_sc};
        r_cmp_r <= r_sr;
        r_cmp_c <= r_sc;
        if (r_cmp_v && (g_rdata == r_in.data_byte)) begin
            r_found <= 1'b1;
            r_fr    <= r_cmp_r;
            r_fc    <= r_cmp_c;
        end
        case (r_state)
            S_IDLE: begin
                r_cmp_v <= 1'b0;
                r_sr    <= '0;
                r_sc    <= '0;
                if (i_start) begin
                    r_in    <= i_in;
                    r_found <= 1'b0;
                    r_fr    <= '0;
                    r_fc    <= '0;
                    case (i_in.op)
                        elf4_pkg::OP_RESTART: r_state <= S_COPY;
                        elf4_pkg::OP_ENCRYPT,
                        elf4_pkg::OP_DECRYPT: r_state <= S_SCAN;
                        default:              r_state <= S_IDLE;
                    endcase
                end
            end
            S_COPY: begin
                r_cp_v <= 1'b1;
                if (r_sc == LAST_POS) begin
                    r_sc <= '0;
                    r_sr <= r_sr + 1'b1;
                    if (r_sr == LAST_POS) begin
                        r_state <= S_COPYW;
                    end
                end else begin
                    r_sc <= r_sc + 1'b1;
                end
            end
            S_COPYW: begin
                r_mrow  <= '0;
                r_mcol  <= '0;
                r_state <= S_IDLE;
            end
            S_SCAN: begin
                r_cmp_v <= 1'b1;
                if (r_sc == LAST_POS) begin
                    r_sc <= '0;
                    r_sr <= r_sr + 1'b1;
                    if (r_sr == LAST_POS) begin
                        r_state <= S_MARK;
                    end
                end else begin
                    r_sc <= r_sc + 1'b1;
                end
            end
            S_MARK: begin
                r_cmp_v <= 1'b0;
                r_state <= S_MVAL;
            end
            S_MVAL: begin
                if (is_enc) begin
                    r_pr <= r_fr;
                    r_pc <= r_fc;
                    r_cr <= e_cr;
                    r_cc <= e_cc;
                end else begin
                    r_pr <= d_pr;
                    r_pc <= d_pc;
                    r_cr <= r_fr;
                    r_cc <= r_fc;
                end
                r_state <= S_RES;
            end
            S_RES: begin
                r_state <= S_RESW;
            end
            S_RESW: begin
                r_res   <= g_rdata;
                r_k     <= '0;
                r_state <= S_ROW;
            end
            S_ROW: begin
                if (r_k == SIDE_K) begin
                    r_k <= '0;
                    if (r_cr == r_pr) begin
                        r_cc <= cc_next;
                    end
                    r_state <= S_COL;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_COL: begin
                if (r_k == SIDE_K) begin
                    r_mrow <= mrow2;
                    r_mcol <= mcol2;
                    r_valid <= 1'b1;
                    r_out.result_byte    <= r_res;
                    r_out.symbol_missing <= !r_found;
                    r_state <= S_IDLE;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            default: begin
                r_state <= S_IDLE;
            end
        endcase
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cmp_v <= 1'b0;
            r_cp_v  <= 1'b0;
            r_mrow  <= '0;
            r_mcol  <= '0;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

`ifndef SYNTHESIS
    // a result beat lasts one cycle only
    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    // a cipher command makes the block busy
    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_in.op == elf4_pkg::OP_ENCRYPT ||
         i_in.op == elf4_pkg::OP_DECRYPT)) |=> o_busy)
        else $error("cipher command did not start");

    // marker stays inside the grid
    a_marker_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mrow <= LAST_POS) && (r_mcol <= LAST_POS))
        else $error("marker outside the grid");

    // a result only appears as the controller returns to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE) && $past(r_state == S_COL))
        else $error("result outside the end of a step");
`endif

endmodule
`default_nettype wire

/* verif/tb_elsiefour_byte_cipher_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_elsiefour_byte_cipher_core
// self-checking bench for the 16 x 16 lc4 byte cipher core: a local copy of
// the key store, grid and marker predicts every result beat, which is
// checked field by field as it leaves the core. directed key loads,
// restarts, extreme bytes, absent and repeated symbols come first, then a
// long random mix of encrypt / decrypt runs with key edits and restarts
// ----------------------------------------------------------------------------
module tb_elsiefour_byte_cipher_core;

    localparam int N = elf4_pkg::GRID_SIDE_DEF;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           i_start = 1'b0;
    elf4_pkg::t_in  i_in    = '0;
    logic           o_busy;
    logic           o_valid;
    elf4_pkg::t_out o_out;

    // predictor state
    logic [7:0] key_bytes [256];
    logic [7:0] cipher_grid [N][N];
    int         marker_r;
    int         marker_c;

    elf4_pkg::t_out expected_bytes [$];
    int   err_count   = 0;
    int   beats_sent  = 0;
    int   bytes_seen  = 0;
    int   missing_seen = 0;
    int   burst_left  = 0;

    elsiefour_byte_cipher_core DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .o_busy (o_busy),
        .i_in   (i_in),
        .o_valid(o_valid),
        .o_out  (o_out)
    );

    // clock
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #100_000_000;
        $display("tb_elsiefour_byte_cipher_core: errors");
        $finish;
    end

    // one command applied to the local cipher state
    function automatic logic cipher_step(input elf4_pkg::t_in cmd,
                                         output elf4_pkg::t_out res);
        int fr, fc, pr, pc, cr, cc, dr, dc;
        logic       found;
        logic [7:0] mval, cbyte, last;
        fr = 0;
        fc = 0;
        found = 1'b0;
        res = '0;
        if (cmd.op == elf4_pkg::OP_LOAD) begin
            key_bytes[cmd.key_index] = cmd.data_byte;
            return 1'b0;
        end
        if (cmd.op == elf4_pkg::OP_RESTART) begin
            for (int r = 0; r < N; r++)
                for (int c = 0; c < N; c++)
                    cipher_grid[r][c] = key_bytes[r * 16 + c];
            marker_r = 0;
            marker_c = 0;
            return 1'b0;
        end
        // last match in row-major order wins
        for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++)
                if (cipher_grid[r][c] == cmd.data_byte) begin
                    fr = r;
                    fc = c;
                    found = 1'b1;
                end
        mval = cipher_grid[marker_r][marker_c];
        dr = int'(mval[7:4]) % N;
        dc = int'(mval[3:0]) % N;
        if (cmd.op == elf4_pkg::OP_ENCRYPT) begin
            pr = fr;
            pc = fc;
            cr = (fr + dr) % N;
            cc = (fc + dc) % N;
            res.result_byte = cipher_grid[cr][cc];
            cbyte = res.result_byte;
        end else begin
            cr = fr;
            cc = fc;
            pr = (fr + N - dr) % N;
            pc = (fc + N - dc) % N;
            res.result_byte = cipher_grid[pr][pc];
            cbyte = cmd.data_byte;
        end
        res.symbol_missing = ~found;
        // plaintext row right by one
        last = cipher_grid[pr][N-1];
        for (int k = N - 1; k > 0; k--)
            cipher_grid[pr][k] = cipher_grid[pr][k-1];
        cipher_grid[pr][0] = last;
        if (cr == pr)
            cc = (cc + 1) % N;
        if (marker_r == pr)
            marker_c = (marker_c + 1) % N;
        // ciphertext column down by one
        last = cipher_grid[N-1][cc];
        for (int k = N - 1; k > 0; k--)
            cipher_grid[k][cc] = cipher_grid[k-1][cc];
        cipher_grid[0][cc] = last;
        if (marker_c == cc)
            marker_r = (marker_r + 1) % N;
        marker_r = (marker_r + int'(cbyte[7:4])) % N;
        marker_c = (marker_c + int'(cbyte[3:0])) % N;
        return 1'b1;
    endfunction

    // drop start for the given number of cycles
    task automatic hold_off(input int cycles);
        i_start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // send one beat, bursts with random gaps between them
    task automatic send_cmd(input elf4_pkg::t_op op, input logic [7:0] idx,
                            input logic [7:0] data);
        elf4_pkg::t_in  cmd;
        elf4_pkg::t_out res;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
                0: ;
                1: hold_off($urandom_range(1, 3));
                2: hold_off($urandom_range(1, 40));
                default: hold_off($urandom_range(1, 320));
            endcase
        end
        burst_left--;
        cmd.op = op;
        cmd.key_index = idx;
        cmd.data_byte = data;
        i_start <= 1'b1;
        i_in    <= cmd;
        do @(posedge i_clk); while (o_busy);
        beats_sent++;
        if (cipher_step(cmd, res))
            expected_bytes.push_back(res);
    endtask

    task automatic drain_results();
        hold_off(1);
        while (expected_bytes.size() != 0) @(posedge i_clk);
    endtask

    // result checker
    always @(posedge i_clk) begin
        elf4_pkg::t_out exp_b;
        if (i_rst_n && o_valid) begin
            if (expected_bytes.size() == 0) begin
                $error("result beat with nothing expected: %h", o_out);
                err_count++;
            end else begin
                exp_b = expected_bytes.pop_front();
                bytes_seen++;
                if (o_out.symbol_missing)
                    missing_seen++;
                if (o_out.result_byte !== exp_b.result_byte) begin
                    $error("result_byte expected %h actual %h",
                           exp_b.result_byte, o_out.result_byte);
                    err_count++;
                end
                if (o_out.symbol_missing !== exp_b.symbol_missing) begin
                    $error("symbol_missing expected %b actual %b",
                           exp_b.symbol_missing, o_out.symbol_missing);
                    err_count++;
                end
            end
        end
    end

    // key is a shuffled permutation of all 256 bytes
    task automatic test_load_key();
        logic [7:0] perm [256];
        logic [7:0] tmp;
        int j;
        for (int i = 0; i < 256; i++)
            perm[i] = i[7:0];
        for (int i = 255; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
        end
        for (int i = 0; i < 256; i++)
            send_cmd(elf4_pkg::OP_LOAD, i[7:0], perm[i]);
    endtask

    // extreme bytes both ways, then a restart and a decrypt of 80
    task automatic test_extremes();
        send_cmd(elf4_pkg::OP_RESTART, 8'h00, 8'h00);
        send_cmd(elf4_pkg::OP_ENCRYPT, 8'hFF, 8'h00);
        send_cmd(elf4_pkg::OP_ENCRYPT, 8'h00, 8'hFF);
        send_cmd(elf4_pkg::OP_DECRYPT, 8'hFF, 8'h00);
        send_cmd(elf4_pkg::OP_DECRYPT, 8'h00, 8'hFF);
        send_cmd(elf4_pkg::OP_ENCRYPT, 8'h5A, 8'hA5);
        send_cmd(elf4_pkg::OP_RESTART, 8'hFF, 8'hFF);
        send_cmd(elf4_pkg::OP_DECRYPT, 8'h00, 8'h80);
        drain_results();
    endtask

    // repeated symbol leaves the overwritten bytes absent from the grid
    task automatic test_absent_and_repeated();
        logic [7:0] gone [3];
        gone[0] = key_bytes[8'h00];
        gone[1] = key_bytes[8'hFF];
        gone[2] = key_bytes[8'h77];
        send_cmd(elf4_pkg::OP_LOAD, 8'h00, 8'h3C);
        send_cmd(elf4_pkg::OP_LOAD, 8'hFF, 8'h3C);
        send_cmd(elf4_pkg::OP_LOAD, 8'h77, 8'h3C);
        send_cmd(elf4_pkg::OP_RESTART, 8'h00, 8'h00);
        send_cmd(elf4_pkg::OP_ENCRYPT, 8'h00, 8'h3C);
        send_cmd(elf4_pkg::OP_DECRYPT, 8'h00, 8'h3C);
        // the overwritten key bytes are now absent from the grid
        for (int i = 0; i < 3; i++) begin
            send_cmd(elf4_pkg::OP_ENCRYPT, 8'h00, gone[i]);
            send_cmd(elf4_pkg::OP_DECRYPT, 8'h00, gone[i]);
        end
        for (int i = 0; i < 4; i++)
            send_cmd(elf4_pkg::OP_ENCRYPT, 8'h00, 8'($urandom));
        drain_results();
    endtask

    // mostly cipher runs with random bytes, some key edits and restarts
    task automatic test_random_traffic(input int count);
        int sel;
        for (int i = 0; i < count; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 45)
                send_cmd(elf4_pkg::OP_ENCRYPT, 8'($urandom), 8'($urandom));
            else if (sel < 85)
                send_cmd(elf4_pkg::OP_DECRYPT, 8'($urandom), 8'($urandom));
            else if (sel < 97)
                send_cmd(elf4_pkg::OP_LOAD, 8'($urandom), 8'($urandom));
            else
                send_cmd(elf4_pkg::OP_RESTART, 8'($urandom), 8'($urandom));
            if (i % 250 == 249)
                drain_results();
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_load_key();
        test_extremes();
        test_absent_and_repeated();
        test_load_key();
        send_cmd(elf4_pkg::OP_RESTART, 8'h00, 8'h00);
        test_random_traffic(800);
        drain_results();
        repeat (N * N + 2 * N + 20) @(posedge i_clk);
        $display("covered %0d command beats and %0d result beats, %0d with an absent symbol",
                 beats_sent, bytes_seen, missing_seen);
        if (err_count == 0 && expected_bytes.size() == 0)
            $display("tb_elsiefour_byte_cipher_core: clean");
        else
            $display("tb_elsiefour_byte_cipher_core: errors");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/elf4_pkg.sv
hw/rtl/elf4_ram.sv
hw/rtl/elsiefour_byte_cipher_core.sv
verif/tb_elsiefour_byte_cipher_core.sv
